// ----- rtl/core/prot_pkg.sv -----
// Shared types, constants and the arctangent table for the plane rotation block.
// Depends on nothing; compile first.
package prot_pkg;

   // defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 16;

   // word field widths
   localparam int FIELD_W  = 32;
   localparam int AXIS_W   = 2;
   localparam int NUM_COMP = 4;

   // angle units: Q16.16 degrees
   localparam longint DEG_Q         = 65536;
   localparam longint DEG_HALF_TURN = 180;
   localparam longint FULL_TURN     = 2 * DEG_HALF_TURN * DEG_Q;
   localparam longint HALF_TURN     = DEG_HALF_TURN * DEG_Q;
   localparam longint QUARTER_TURN  = HALF_TURN / 2;

   // angle reduction: bias to non-negative, then restoring subtract of full turns
   localparam longint ANGLE_OFFSET = ((longint'(1) << (FIELD_W - 1)) / FULL_TURN + 1) * FULL_TURN;
   localparam int     ANGLE_W      = FIELD_W + 2;
   localparam int     MOD_STEPS    = 9;
   localparam int     REM_W        = 25;

   // CORDIC datapath
   localparam int     XY_W           = 34;
   localparam int     Z_W            = 26;
   localparam int     ATAN_W         = 22;
   localparam int     TRIG_ONE_SHIFT = 30;
   localparam longint CORDIC_GAIN_Q30 = 652032874;

   // input word
   typedef struct packed {
      logic signed [FIELD_W-1:0] comp_x;
      logic signed [FIELD_W-1:0] comp_y;
      logic signed [FIELD_W-1:0] comp_z;
      logic signed [FIELD_W-1:0] comp_t;
      logic signed [FIELD_W-1:0] angle_deg;
      logic [AXIS_W-1:0]         first_axis;
      logic [AXIS_W-1:0]         second_axis;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [FIELD_W-1:0] res_x;
      logic signed [FIELD_W-1:0] res_y;
      logic signed [FIELD_W-1:0] res_z;
      logic signed [FIELD_W-1:0] res_t;
   } rsp_word_type;

   // vector and plane carried down the pipeline, comp[0] is x
   typedef struct packed {
      logic [NUM_COMP-1:0][FIELD_W-1:0] comp;
      logic [AXIS_W-1:0]                first_axis;
      logic [AXIS_W-1:0]                second_axis;
   } vec_type;

   // atan(2^-i) in Q16.16 degrees
   function automatic logic [ATAN_W-1:0] atan_deg_q16(input int idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         0:       val = ATAN_W'(2949120);
         1:       val = ATAN_W'(1740967);
         2:       val = ATAN_W'(919879);
         3:       val = ATAN_W'(466945);
         4:       val = ATAN_W'(234379);
         5:       val = ATAN_W'(117304);
         6:       val = ATAN_W'(58666);
         7:       val = ATAN_W'(29335);
         8:       val = ATAN_W'(14668);
         9:       val = ATAN_W'(7334);
         10:      val = ATAN_W'(3667);
         11:      val = ATAN_W'(1833);
         12:      val = ATAN_W'(917);
         13:      val = ATAN_W'(458);
         14:      val = ATAN_W'(229);
         15:      val = ATAN_W'(115);
         16:      val = ATAN_W'(57);
         17:      val = ATAN_W'(29);
         18:      val = ATAN_W'(14);
         19:      val = ATAN_W'(7);
         20:      val = ATAN_W'(4);
         21:      val = ATAN_W'(2);
         22:      val = ATAN_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/prot_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from prot_pkg at the instance.
interface prot_chan_if #(
   parameter type word_type = logic
) ();

   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/core/plane_rotation_by_degrees.sv -----
// Plane rotation of a four-component Q16.16 vector by an angle in degrees.
// Depends on prot_pkg and prot_chan_if.
//
// Usage:
//   req_bus carries one word per handshake: the vector (comp_x..comp_t), the
//   angle in Q16.16 degrees and the two axes of the rotation plane. rsp_bus
//   returns one word per request with the rotated, saturated vector, in
//   request order. A word moves when valid and ready are both high.
// Stages: one load stage, nine angle-reduction stages, a quadrant fold, one
//   CORDIC stage per iteration, then trig rounding, products, sums and
//   saturation, each registered.
// Throughput: one word per cycle while rsp ready is high; every stage holds
//   its own valid bit.
// Stall: when rsp ready is low the last stage holds its word; stages behind
//   it keep filling any bubbles, so req ready drops only once the whole
//   pipeline is full. Nothing is dropped or repeated.
// Reset: synchronous, active high; clears all valid bits, the pipeline is
//   empty and req ready is high on the next cycle.
module plane_rotation_by_degrees #(
   parameter int COORD_WIDTH   = prot_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = prot_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   prot_chan_if.sink   req_bus,
   prot_chan_if.source rsp_bus
);

   import prot_pkg::*;

   // arithmetic widths
   localparam int TRIG_FRAC = ((61 - COORD_WIDTH) < TRIG_ONE_SHIFT) ?
                              (61 - COORD_WIDTH) : TRIG_ONE_SHIFT;
   localparam int TRIG_SH   = TRIG_ONE_SHIFT - TRIG_FRAC;
   localparam int TRIG_W    = TRIG_FRAC + 3;
   localparam int PROD_W    = FIELD_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 2;

   // stage map
   localparam int FOLD_ST = MOD_STEPS + 1;
   localparam int TRIG_ST = FOLD_ST + CORDIC_STAGES + 1;
   localparam int MULT_ST = TRIG_ST + 1;
   localparam int SUM_ST  = TRIG_ST + 2;
   localparam int OUT_ST  = TRIG_ST + 3;
   localparam int NUM_ST  = OUT_ST + 1;

   localparam logic signed [SUM_W-1:0] SAT_MAX =
      SUM_W'((longint'(1) << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(longint'(1) << (TRIG_FRAC - 1));

   localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(QUARTER_TURN);
   localparam logic signed [Z_W-1:0] THREEQ_Z  = Z_W'(3 * QUARTER_TURN);
   localparam logic signed [Z_W-1:0] HALF_Z    = Z_W'(HALF_TURN);
   localparam logic signed [Z_W-1:0] FULL_Z    = Z_W'(FULL_TURN);

   // pipeline control
   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] valid_in;
   logic [NUM_ST:0]   adv;
   logic [NUM_ST-1:0] ld;

   // datapath registers
   vec_type                   vec_ff [NUM_ST];
   logic [ANGLE_W-1:0]        ang_ff [MOD_STEPS+1];
   logic [ANGLE_W-1:0]        ang_in [MOD_STEPS+1];
   logic signed [XY_W-1:0]    cx_ff  [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]    cx_in  [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]    cy_ff  [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]    cy_in  [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]     cz_ff  [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]     cz_in  [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0]    neg_ff;
   logic [CORDIC_STAGES:0]    neg_in;
   logic signed [TRIG_W-1:0]  cs_ff, cs_in;
   logic signed [TRIG_W-1:0]  sn_ff, sn_in;
   logic signed [PROD_W-1:0]  pcs_ff, pcs_in;
   logic signed [PROD_W-1:0]  qnsn_ff, qnsn_in;
   logic signed [PROD_W-1:0]  psn_ff, psn_in;
   logic signed [PROD_W-1:0]  qcs_ff, qcs_in;
   logic signed [SUM_W-1:0]   suma_ff, suma_in;
   logic signed [SUM_W-1:0]   sumb_ff, sumb_in;
   rsp_word_type              rsp_ff, rsp_in;

   // saturate to the coordinate width, keep the low field bits
   function automatic logic [FIELD_W-1:0] sat_low(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end else begin
         r = v;
      end
      return r[FIELD_W-1:0];
   endfunction

   // stage s may load when it is empty or its word moves on
   assign adv[NUM_ST] = rsp_bus.ready;

   for (genvar s = 0; s < NUM_ST; s++) begin : g_ctl
      assign adv[s] = !valid_ff[s] || adv[s+1];
      if (s == 0) begin : g_first
         assign ld[s]       = adv[s] && req_bus.valid;
         assign valid_in[s] = adv[s] ? req_bus.valid : valid_ff[s];
      end else begin : g_rest
         assign ld[s]       = adv[s] && valid_ff[s-1];
         assign valid_in[s] = adv[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = adv[0];
   assign rsp_bus.valid = valid_ff[OUT_ST];
   assign rsp_bus.data  = rsp_ff;

   // load stage: capture the vector, bias the angle to a non-negative value
   always_comb begin
      ang_in[0] = ANGLE_W'(ANGLE_W'(req_bus.data.angle_deg) + ANGLE_W'(ANGLE_OFFSET));
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         vec_ff[0].comp        <= {req_bus.data.comp_t, req_bus.data.comp_z,
                                   req_bus.data.comp_y, req_bus.data.comp_x};
         vec_ff[0].first_axis  <= req_bus.data.first_axis;
         vec_ff[0].second_axis <= req_bus.data.second_axis;
         ang_ff[0]             <= ang_in[0];
      end
   end

   // carry the vector alongside the arithmetic
   for (genvar s = 1; s < NUM_ST; s++) begin : g_vec
      always_ff @(posedge clock) begin
         if (ld[s]) begin
            vec_ff[s] <= vec_ff[s-1];
         end
      end
   end

   // angle reduction: subtract full turns scaled by 2^8 down to 2^0
   for (genvar s = 1; s <= MOD_STEPS; s++) begin : g_mod
      localparam logic [ANGLE_W-1:0] STEP = ANGLE_W'(FULL_TURN) << (MOD_STEPS - s);

      always_comb begin
         if (ang_ff[s-1] >= STEP) begin
            ang_in[s] = ang_ff[s-1] - STEP;
         end else begin
            ang_in[s] = ang_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ld[s]) begin
            ang_ff[s] <= ang_in[s];
         end
      end
   end

   // quadrant fold into [-90, 90] and seed the rotator
   always_comb begin
      logic signed [Z_W-1:0] z0;
      z0 = Z_W'(ang_ff[MOD_STEPS][REM_W-1:0]);
      cx_in[0] = XY_W'(CORDIC_GAIN_Q30);
      cy_in[0] = '0;
      if (z0 <= QUARTER_Z) begin
         cz_in[0]  = z0;
         neg_in[0] = 1'b0;
      end else if (z0 < THREEQ_Z) begin
         cz_in[0]  = z0 - HALF_Z;
         neg_in[0] = 1'b1;
      end else begin
         cz_in[0]  = z0 - FULL_Z;
         neg_in[0] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[FOLD_ST]) begin
         cx_ff[0]  <= cx_in[0];
         cy_ff[0]  <= cy_in[0];
         cz_ff[0]  <= cz_in[0];
         neg_ff[0] <= neg_in[0];
      end
   end

   // CORDIC rotation, one micro-rotation per stage
   for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_cordic
      localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(atan_deg_q16(i - 1));

      always_comb begin
         logic signed [XY_W-1:0] xs;
         logic signed [XY_W-1:0] ys;
         xs = cx_ff[i-1] >>> (i - 1);
         ys = cy_ff[i-1] >>> (i - 1);
         neg_in[i] = neg_ff[i-1];
         if (cz_ff[i-1] >= 0) begin
            cx_in[i] = cx_ff[i-1] - ys;
            cy_in[i] = cy_ff[i-1] + xs;
            cz_in[i] = cz_ff[i-1] - ATAN_I;
         end else begin
            cx_in[i] = cx_ff[i-1] + ys;
            cy_in[i] = cy_ff[i-1] - xs;
            cz_in[i] = cz_ff[i-1] + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[FOLD_ST + i]) begin
            cx_ff[i]  <= cx_in[i];
            cy_ff[i]  <= cy_in[i];
            cz_ff[i]  <= cz_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
   end

   // undo the fold, round cosine and sine half up to TRIG_FRAC bits
   always_comb begin
      logic signed [XY_W-1:0] xn;
      logic signed [XY_W-1:0] yn;
      if (neg_ff[CORDIC_STAGES]) begin
         xn = -cx_ff[CORDIC_STAGES];
         yn = -cy_ff[CORDIC_STAGES];
      end else begin
         xn = cx_ff[CORDIC_STAGES];
         yn = cy_ff[CORDIC_STAGES];
      end
      if (TRIG_SH == 0) begin
         cs_in = TRIG_W'(xn);
         sn_in = TRIG_W'(yn);
      end else begin
         cs_in = TRIG_W'((xn + XY_W'(longint'(1) << (TRIG_SH - 1))) >>> TRIG_SH);
         sn_in = TRIG_W'((yn + XY_W'(longint'(1) << (TRIG_SH - 1))) >>> TRIG_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[TRIG_ST]) begin
         cs_ff <= cs_in;
         sn_ff <= sn_in;
      end
   end

   // select the plane components and form the four products
   always_comb begin
      logic signed [FIELD_W-1:0] p;
      logic signed [FIELD_W-1:0] q;
      logic signed [TRIG_W-1:0]  nsn;
      p   = $signed(vec_ff[TRIG_ST].comp[vec_ff[TRIG_ST].first_axis]);
      q   = $signed(vec_ff[TRIG_ST].comp[vec_ff[TRIG_ST].second_axis]);
      nsn = -sn_ff;
      pcs_in  = PROD_W'(p * cs_ff);
      qnsn_in = PROD_W'(q * nsn);
      psn_in  = PROD_W'(p * sn_ff);
      qcs_in  = PROD_W'(q * cs_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[MULT_ST]) begin
         pcs_ff  <= pcs_in;
         qnsn_ff <= qnsn_in;
         psn_ff  <= psn_in;
         qcs_ff  <= qcs_in;
      end
   end

   // add product pairs with the rounding half
   always_comb begin
      suma_in = SUM_W'(pcs_ff) + SUM_W'(qnsn_ff) + ROUND_C;
      sumb_in = SUM_W'(psn_ff) + SUM_W'(qcs_ff) + ROUND_C;
   end

   always_ff @(posedge clock) begin
      if (ld[SUM_ST]) begin
         suma_ff <= suma_in;
         sumb_ff <= sumb_in;
      end
   end

   // drop the fraction, saturate, place rotated values; second axis wins a tie
   always_comb begin
      logic [NUM_COMP-1:0][FIELD_W-1:0] res;
      logic signed [SUM_W-1:0]          ra;
      logic signed [SUM_W-1:0]          rb;
      ra = suma_ff >>> TRIG_FRAC;
      rb = sumb_ff >>> TRIG_FRAC;
      for (int k = 0; k < NUM_COMP; k++) begin
         res[k] = sat_low(SUM_W'($signed(vec_ff[SUM_ST].comp[k])));
         if (vec_ff[SUM_ST].first_axis == AXIS_W'(k)) begin
            res[k] = sat_low(ra);
         end
         if (vec_ff[SUM_ST].second_axis == AXIS_W'(k)) begin
            res[k] = sat_low(rb);
         end
      end
      rsp_in.res_x = $signed(res[0]);
      rsp_in.res_y = $signed(res[1]);
      rsp_in.res_z = $signed(res[2]);
      rsp_in.res_t = $signed(res[3]);
   end

   always_ff @(posedge clock) begin
      if (ld[OUT_ST]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for the plane rotation block: random and corner words in,
// predicted rotated vectors compared field by field. Needs prot_pkg and
// prot_chan_if from the RTL; top is testbench, the block is dut.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import prot_pkg::*;

   localparam int     ROT_W       = COORD_WIDTH_DEF;
   localparam int     STAGES      = CORDIC_STAGES_DEF;
   localparam int     TRIG_FRAC   = ((61 - ROT_W) < 30) ? (61 - ROT_W) : 30;
   localparam int     TRIG_SHIFT  = TRIG_ONE_SHIFT - TRIG_FRAC;
   localparam int     IDLE_PCT    = 22;
   localparam int     RANDOM_WORDS = 750;
   localparam int     DRAIN_CYCLES = CORDIC_STAGES_DEF + 40;
   localparam int     MAX_REPORTS  = 10;
   localparam longint DEG_ONE     = 65536;
   localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;
   localparam logic [1:0]  AXIS_X = 2'd0, AXIS_Y = 2'd1, AXIS_Z = 2'd2, AXIS_T = 2'd3;

   logic clock;
   logic reset;

   prot_chan_if #(.word_type(req_word_type)) req_bus ();
   prot_chan_if #(.word_type(rsp_word_type)) rsp_bus ();

   plane_rotation_by_degrees dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // arctangent of 2^-i in Q16.16 degrees
   longint atan_step_deg [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   req_word_type pending_words [$];
   rsp_word_type rotated_expect [$];
   int  words_taken;
   int  fail_count;
   bit  req_taken;
   bit  quiet;

   // weighted sum of two products, rounded half up, then clipped to ROT_W bits
   function automatic longint mix_and_clip(input longint a, input longint ka,
                                           input longint b, input longint kb);
      longint sum;
      longint lim;
      lim = longint'(1) <<< (ROT_W - 1);
      sum = a * ka + b * kb;
      sum = (sum + (longint'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      if (sum > lim - 1) sum = lim - 1;
      if (sum < -lim) sum = -lim;
      return sum;
   endfunction

   // expected output word for one input word
   function automatic rsp_word_type rotate_in_plane(input req_word_type w);
      longint       comp [4];
      longint       z, x, y, xs, ys, p, q, sn, cs;
      bit           flip;
      int           fa, sa;
      rsp_word_type r;
      comp[0] = $signed(w.comp_x);
      comp[1] = $signed(w.comp_y);
      comp[2] = $signed(w.comp_z);
      comp[3] = $signed(w.comp_t);
      fa = w.first_axis;
      sa = w.second_axis;

      // reduce to [-180, 180), fold into [-90, 90]
      z = longint'($signed(w.angle_deg)) % FULL_TURN;
      if (z < 0) z += FULL_TURN;
      if (z >= HALF_TURN) z -= FULL_TURN;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
         z -= HALF_TURN;
         flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z += HALF_TURN;
         flip = 1'b1;
      end

      // CORDIC rotation mode, Q2.30
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= atan_step_deg[i];
         end else begin
            x += ys;
            y -= xs;
            z += atan_step_deg[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      if (TRIG_SHIFT != 0) begin
         x = (x + (longint'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
         y = (y + (longint'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
      end
      cs = x;
      sn = y;

      // same axis twice: second assignment wins
      p = comp[fa];
      q = comp[sa];
      comp[fa] = mix_and_clip(p, cs, q, -sn);
      comp[sa] = mix_and_clip(p, sn, q, cs);
      r.res_x = comp[0][31:0];
      r.res_y = comp[1][31:0];
      r.res_z = comp[2][31:0];
      r.res_t = comp[3][31:0];
      return r;
   endfunction

   function automatic logic [31:0] pick_comp();
      if ($urandom_range(0, 99) < 60) return $urandom;
      return 32'(int'($urandom_range(0, 2097151)) - 1048576);
   endfunction

   task automatic queue_word(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] t,
                             input logic [31:0] ang, input logic [1:0] a,
                             input logic [1:0] b);
      req_word_type w;
      w.comp_x      = x;
      w.comp_y      = y;
      w.comp_z      = z;
      w.comp_t      = t;
      w.angle_deg   = ang;
      w.first_axis  = a;
      w.second_axis = b;
      pending_words.push_back(w);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // no idling on either side for a stretch in the middle of the run
   assign quiet = (words_taken >= 300) && (words_taken < 450);

   // record accepted input words and predict their results
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         rotated_expect.push_back(rotate_in_plane(req_bus.data));
         words_taken <= words_taken + 1;
      end
   end

   // drive input words from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_bus.data  <= pending_words.pop_front();
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // stall the result side at random
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rotated_expect.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: result word with nothing expected: %h", $realtime, rsp_bus.data);
         end else begin
            want = rotated_expect.pop_front();
            check_field("res_x", want.res_x, rsp_bus.data.res_x);
            check_field("res_y", want.res_y, rsp_bus.data.res_y);
            check_field("res_z", want.res_z, rsp_bus.data.res_z);
            check_field("res_t", want.res_t, rsp_bus.data.res_t);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [31:0] spec_angles [16];
      logic [31:0] cx, cy, cz;
      int          k;
      words_taken = 0;
      fail_count  = 0;
      spec_angles = '{
         32'd0, 32'(90 * DEG_ONE), 32'(180 * DEG_ONE), 32'(270 * DEG_ONE),
         32'(-90 * DEG_ONE), 32'(-180 * DEG_ONE), 32'(360 * DEG_ONE), 32'(45 * DEG_ONE),
         32'(90 * DEG_ONE + 1), 32'(-90 * DEG_ONE - 1), POS_MAX, NEG_MAX,
         32'(30 * DEG_ONE), 32'(720 * DEG_ONE), 32'(-360 * DEG_ONE), 32'd1
      };

      // every axis pair, same axis included, each with a corner angle
      k = 0;
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            cx = k[0] ? POS_MAX : NEG_MAX;
            cy = k[1] ? NEG_MAX : POS_MAX;
            cz = 32'h0001_0000 * (k + 1);
            queue_word(cx, cy, cz, -cz, spec_angles[k], 2'(a), 2'(b));
            k++;
         end
      end
      queue_word(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, AXIS_X, AXIS_Y);
      queue_word(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'(90 * DEG_ONE), AXIS_X, AXIS_Y);
      queue_word(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 32'(45 * DEG_ONE), AXIS_Z, AXIS_T);
      queue_word(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 32'(225 * DEG_ONE), AXIS_Y, AXIS_T);
      queue_word(POS_MAX, 32'd5, NEG_MAX, 32'd7, 32'(45 * DEG_ONE), AXIS_T, AXIS_T);

      // random words: mix of full-range and near-zero components and angles
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         logic [31:0] ang;
         if ($urandom_range(0, 1) == 0)
            ang = $urandom;
         else
            ang = 32'(int'($urandom_range(0, 1440 * 65536)) - 720 * 65536);
         queue_word(pick_comp(), pick_comp(), pick_comp(), pick_comp(), ang,
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end

      // wait for every word to go in and every result to come back
      @(negedge clock);
      while (reset) @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid) @(posedge clock);
      while (rotated_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && rotated_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop if the pipeline hangs
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
